// ===== design/mbce_pkg.sv =====
// Shared types, constants and register codes of the monochrome color-expansion blit.
package mbce_pkg;

    // Pixels carried by one bitmap byte, one lane per pixel
    localparam int unsigned PIX_PER_BYTE = 8;
    localparam int unsigned LANE_IDX_W   = $clog2(PIX_PER_BYTE);

    // Longest bitmap row in bytes
    localparam logic [9:0] MAX_ROW_BYTES = 10'd512;

    // Configuration port geometry
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    // Register reset values
    localparam logic [2:0]  RST_PIXEL_BYTES   = 3'd3;
    localparam logic [15:0] RST_ROW_PITCH     = 16'd3072;
    localparam logic [23:0] RST_FORE_COLOUR   = 24'hFFFFFF;
    localparam logic [23:0] RST_BACK_COLOUR   = 24'h000000;
    localparam logic [11:0] RST_ORIGIN_X      = 12'd0;
    localparam logic [11:0] RST_ORIGIN_Y      = 12'd0;
    localparam logic [9:0]  RST_BYTES_PER_ROW = 10'd1;
    localparam logic [11:0] RST_ROW_COUNT     = 12'd16;

    // Register index codes (word address)
    typedef enum logic [2:0] {
        REG_PIXEL_BYTES   = 3'd0,
        REG_ROW_PITCH     = 3'd1,
        REG_FORE_COLOUR   = 3'd2,
        REG_BACK_COLOUR   = 3'd3,
        REG_ORIGIN_X      = 3'd4,
        REG_ORIGIN_Y      = 3'd5,
        REG_BYTES_PER_ROW = 3'd6,
        REG_ROW_COUNT     = 3'd7
    } reg_idx_t;

    // Register file contents as seen by the datapath
    typedef struct packed {
        logic [2:0]  pixel_bytes;
        logic [15:0] row_pitch;
        logic [23:0] fore_colour;
        logic [23:0] back_colour;
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [9:0]  bytes_per_row;
        logic [11:0] row_count;
    } cfg_t;

    // One expanded pixel write: offset plus packed RGB (red high)
    typedef struct packed {
        logic [31:0] offset;
        logic [23:0] rgb;
    } pix_t;

endpackage

// ===== design/mbce_ifs.sv =====
// Valid/ready channel interfaces for bitmap input and pixel output.
interface mbce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] bitmap_byte;

    modport source (output valid, output bitmap_byte, input ready);
    modport sink (input valid, input bitmap_byte, output ready);
endinterface

interface mbce_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] byte_offset;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_of_byte;
    logic        end_of_blit;

    modport source (
        output valid, output byte_offset, output red, output green, output blue,
        output last_of_byte, output end_of_blit, input ready
    );
    modport sink (
        input valid, input byte_offset, input red, input green, input blue,
        input last_of_byte, input end_of_blit, output ready
    );
endinterface

// ===== design/mbce_cfg_regs.sv =====
// APB-style configuration register file.
module mbce_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mbce_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mbce_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mbce_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output mbce_pkg::cfg_t                      cfg
);

    mbce_pkg::cfg_t   cfg_reg;
    mbce_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = mbce_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_bytes   <= mbce_pkg::RST_PIXEL_BYTES;
            cfg_reg.row_pitch     <= mbce_pkg::RST_ROW_PITCH;
            cfg_reg.fore_colour   <= mbce_pkg::RST_FORE_COLOUR;
            cfg_reg.back_colour   <= mbce_pkg::RST_BACK_COLOUR;
            cfg_reg.origin_x      <= mbce_pkg::RST_ORIGIN_X;
            cfg_reg.origin_y      <= mbce_pkg::RST_ORIGIN_Y;
            cfg_reg.bytes_per_row <= mbce_pkg::RST_BYTES_PER_ROW;
            cfg_reg.row_count     <= mbce_pkg::RST_ROW_COUNT;
        end
        else if (wr_en)
        begin
            case (idx)
                mbce_pkg::REG_PIXEL_BYTES:   cfg_reg.pixel_bytes   <= pwdata[2:0];
                mbce_pkg::REG_ROW_PITCH:     cfg_reg.row_pitch     <= pwdata[15:0];
                mbce_pkg::REG_FORE_COLOUR:   cfg_reg.fore_colour   <= pwdata[23:0];
                mbce_pkg::REG_BACK_COLOUR:   cfg_reg.back_colour   <= pwdata[23:0];
                mbce_pkg::REG_ORIGIN_X:      cfg_reg.origin_x      <= pwdata[11:0];
                mbce_pkg::REG_ORIGIN_Y:      cfg_reg.origin_y      <= pwdata[11:0];
                mbce_pkg::REG_BYTES_PER_ROW: cfg_reg.bytes_per_row <= pwdata[9:0];
                mbce_pkg::REG_ROW_COUNT:     cfg_reg.row_count     <= pwdata[11:0];
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            mbce_pkg::REG_PIXEL_BYTES:   prdata = 32'(cfg_reg.pixel_bytes);
            mbce_pkg::REG_ROW_PITCH:     prdata = 32'(cfg_reg.row_pitch);
            mbce_pkg::REG_FORE_COLOUR:   prdata = 32'(cfg_reg.fore_colour);
            mbce_pkg::REG_BACK_COLOUR:   prdata = 32'(cfg_reg.back_colour);
            mbce_pkg::REG_ORIGIN_X:      prdata = 32'(cfg_reg.origin_x);
            mbce_pkg::REG_ORIGIN_Y:      prdata = 32'(cfg_reg.origin_y);
            mbce_pkg::REG_BYTES_PER_ROW: prdata = 32'(cfg_reg.bytes_per_row);
            mbce_pkg::REG_ROW_COUNT:     prdata = 32'(cfg_reg.row_count);
            default:                     prdata = '0;
        endcase
    end

endmodule

// ===== design/mbce_lane.sv =====
// One pixel lane: offset and color of a single bit of the bitmap byte.
module mbce_lane #(
    parameter int unsigned LANE = 0
) (
    input  logic                 clk,
    input  logic                 load,
    input  logic [31:0]          base,
    input  logic [2:0]           pixel_bytes,
    input  logic                 pix_bit,
    input  logic [23:0]          fore_colour,
    input  logic [23:0]          back_colour,
    output mbce_pkg::pix_t       pix
);

    logic [5:0]     step;
    mbce_pkg::pix_t pix_reg;
    mbce_pkg::pix_t pix_next;

    // Lane position times pixel size
    assign step = 6'(pixel_bytes) * 6'(LANE);

    always_comb
    begin
        pix_next.offset = base + 32'(step);
        pix_next.rgb    = pix_bit ? fore_colour : back_colour;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix = pix_reg;

endmodule

// ===== design/mbce_serializer.sv =====
// Merge stage: takes the eight lane results and sends them out one per cycle while the output is ready.
module mbce_serializer (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  mbce_pkg::pix_t [mbce_pkg::PIX_PER_BYTE-1:0] lane_pix,
    input  logic                                        lane_eob,
    input  logic                                        lane_vld,
    output logic                                        lane_take,
    mbce_out_if.source                                  pixels
);

    localparam logic [mbce_pkg::LANE_IDX_W-1:0] LAST_IDX =
        mbce_pkg::LANE_IDX_W'(mbce_pkg::PIX_PER_BYTE - 1);

    mbce_pkg::pix_t [mbce_pkg::PIX_PER_BYTE-1:0] buf_reg;
    logic                                        eob_reg;
    logic [mbce_pkg::LANE_IDX_W-1:0]             cnt_reg;
    logic [mbce_pkg::LANE_IDX_W-1:0]             cnt_next;
    logic                                        vld_reg;
    logic                                        vld_next;
    logic                                        fire;
    logic                                        is_last;

    assign fire      = vld_reg && pixels.ready;
    assign is_last   = (cnt_reg == LAST_IDX);
    assign lane_take = lane_vld && (!vld_reg || (fire && is_last));

    // Control: pixel count and valid
    always_comb
    begin
        cnt_next = cnt_reg;
        vld_next = vld_reg;
        if (lane_take)
        begin
            cnt_next = '0;
            vld_next = 1'b1;
        end
        else if (fire)
        begin
            if (is_last)
            begin
                vld_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            vld_reg <= vld_next;
        end
    end

    // Payload: load all lanes, then shift toward entry zero
    always_ff @(posedge clk)
    begin
        if (lane_take)
        begin
            buf_reg <= lane_pix;
            eob_reg <= lane_eob;
        end
        else if (fire)
        begin
            for (int i = 0; i < mbce_pkg::PIX_PER_BYTE - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

    assign pixels.valid        = vld_reg;
    assign pixels.byte_offset  = buf_reg[0].offset;
    assign pixels.red          = buf_reg[0].rgb[23:16];
    assign pixels.green        = buf_reg[0].rgb[15:8];
    assign pixels.blue         = buf_reg[0].rgb[7:0];
    assign pixels.last_of_byte = is_last;
    assign pixels.end_of_blit  = is_last && eob_reg;

endmodule

// ===== design/mono_bitmap_colour_expand_core.sv =====
// Top level of the monochrome color-expansion blit.
// Each accepted bitmap byte (bit 7 leftmost) becomes eight pixel write transactions on the
// output channel, one per cycle while the output is ready, so the sustained rate is set by the
// single output channel. Eight lanes compute a byte's pixels in the cycle it is accepted; the
// merge stage then shifts them out from its buffer, loaded from the lane registers, and the
// next byte is taken while the current one is still going out. Blit geometry and colors come
// from APB registers at word addresses 0..7, which must be written while idle.
module mono_bitmap_colour_expand_core (
    input  logic                                clk,
    input  logic                                rst_n,
    mbce_in_if.sink                             bitmap,
    mbce_out_if.source                          pixels,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mbce_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mbce_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mbce_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    mbce_pkg::cfg_t                              cfg;
    mbce_pkg::pix_t [mbce_pkg::PIX_PER_BYTE-1:0] lane_pix;

    logic [8:0]  col_reg;
    logic [8:0]  col_next;
    logic [11:0] row_reg;
    logic [11:0] row_next;
    logic [31:0] wr_off_reg;
    logic [31:0] wr_off_next;
    logic        lane_vld_reg;
    logic        lane_vld_next;
    logic        lane_eob_reg;
    logic        lane_take;
    logic        accept;

    logic [9:0]  rb_eff;
    logic [11:0] rows_eff;
    logic        row_end;
    logic        blit_end;
    logic        blit_start;
    logic [14:0] ox_term;
    logic [27:0] oy_term;
    logic [31:0] origin;
    logic [31:0] base;
    logic [15:0] row_span;
    logic [31:0] row_adj;

    mbce_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input handshake: lane stage free or emptying this cycle
    assign bitmap.ready = !lane_vld_reg || lane_take;
    assign accept       = bitmap.valid && bitmap.ready;

    // Clamped row length and row count
    always_comb
    begin
        if (cfg.bytes_per_row == '0)
        begin
            rb_eff = 10'd1;
        end
        else if (cfg.bytes_per_row > mbce_pkg::MAX_ROW_BYTES)
        begin
            rb_eff = mbce_pkg::MAX_ROW_BYTES;
        end
        else
        begin
            rb_eff = cfg.bytes_per_row;
        end
        rows_eff = (cfg.row_count == '0) ? 12'd1 : cfg.row_count;
    end

    // Position within the blit
    assign row_end    = ({1'b0, col_reg} + 10'd1) >= rb_eff;
    assign blit_end   = row_end && (({1'b0, row_reg} + 13'd1) >= {1'b0, rows_eff});
    assign blit_start = (col_reg == '0) && (row_reg == '0);

    // Start offset of a blit
    assign ox_term = 15'(cfg.origin_x) * 15'(cfg.pixel_bytes);
    assign oy_term = 28'(cfg.origin_y) * 28'(cfg.row_pitch);
    assign origin  = 32'(ox_term) + 32'(oy_term);
    assign base    = blit_start ? origin : wr_off_reg;

    // Jump from the end of one row to the start of the next
    assign row_span = 16'(cfg.pixel_bytes) * 16'({rb_eff, 3'b000});
    assign row_adj  = row_end ? (32'(cfg.row_pitch) - 32'(row_span)) : 32'd0;

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        wr_off_next = wr_off_reg;
        if (accept)
        begin
            wr_off_next = base + 32'({cfg.pixel_bytes, 3'b000}) + row_adj;
            if (blit_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // Lane stage occupancy
    always_comb
    begin
        lane_vld_next = lane_vld_reg;
        if (accept)
        begin
            lane_vld_next = 1'b1;
        end
        else if (lane_take)
        begin
            lane_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            lane_vld_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            lane_vld_reg <= lane_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_off_reg <= wr_off_next;
        if (accept)
        begin
            lane_eob_reg <= blit_end;
        end
    end

    // Pixel lanes, lane 0 takes bit 7
    for (genvar i = 0; i < mbce_pkg::PIX_PER_BYTE; i++)
    begin : g_lane
        mbce_lane #(
            .LANE (i)
        ) u_lane (
            .clk         (clk),
            .load        (accept),
            .base        (base),
            .pixel_bytes (cfg.pixel_bytes),
            .pix_bit     (bitmap.bitmap_byte[mbce_pkg::PIX_PER_BYTE-1-i]),
            .fore_colour (cfg.fore_colour),
            .back_colour (cfg.back_colour),
            .pix         (lane_pix[i])
        );
    end

    mbce_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_pix  (lane_pix),
        .lane_eob  (lane_eob_reg),
        .lane_vld  (lane_vld_reg),
        .lane_take (lane_take),
        .pixels    (pixels)
    );

endmodule

// ===== tb/mono_bitmap_colour_expand_core_tb.sv =====
// Self-checking testbench for the monochrome color-expansion blit core.
`timescale 1ns / 1ps

module mono_bitmap_colour_expand_core_tb;

    // One expected pixel write transaction
    typedef struct packed {
        logic [31:0] byte_offset;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last_of_byte;
        logic        end_of_blit;
    } pixel_write_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [mbce_pkg::APB_ADDR_W-1:0] paddr;
    logic [mbce_pkg::APB_DATA_W-1:0] pwdata;
    logic [mbce_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    mbce_in_if  bitmap_ch ();
    mbce_out_if pixel_ch ();

    mono_bitmap_colour_expand_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bitmap  (bitmap_ch),
        .pixels  (pixel_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // Bytes waiting to be sent, pixel writes waiting to arrive
    logic [7:0]   queued_bytes[$];
    pixel_write_t pending_pixels[$];
    int unsigned  mismatch_count = 0;

    // Shadow copy of the blit registers and position
    mbce_pkg::cfg_t shadow_cfg;
    logic [31:0]    next_offset;
    logic [8:0]     byte_col;
    logic [11:0]    blit_row;

    function automatic logic [31:0] origin_offset();
        return 32'(shadow_cfg.origin_x) * 32'(shadow_cfg.pixel_bytes)
             + 32'(shadow_cfg.origin_y) * 32'(shadow_cfg.row_pitch);
    endfunction

    // Row length clamps to 1..512 bytes, row count to at least one
    function automatic logic [31:0] row_bytes_eff();
        if (shadow_cfg.bytes_per_row == '0)
            return 32'd1;
        if (shadow_cfg.bytes_per_row > mbce_pkg::MAX_ROW_BYTES)
            return 32'(mbce_pkg::MAX_ROW_BYTES);
        return 32'(shadow_cfg.bytes_per_row);
    endfunction

    function automatic logic [31:0] rows_eff();
        return (shadow_cfg.row_count == '0) ? 32'd1 : 32'(shadow_cfg.row_count);
    endfunction

    // Update the shadow register, return what a read should give back
    function automatic logic [31:0] apply_register(mbce_pkg::reg_idx_t idx,
                                                   logic [31:0] value);
        logic [31:0] stored;
        stored = '0;
        case (idx)
            mbce_pkg::REG_PIXEL_BYTES:
            begin
                shadow_cfg.pixel_bytes = value[2:0];
                stored = 32'(value[2:0]);
            end
            mbce_pkg::REG_ROW_PITCH:
            begin
                shadow_cfg.row_pitch = value[15:0];
                stored = 32'(value[15:0]);
            end
            mbce_pkg::REG_FORE_COLOUR:
            begin
                shadow_cfg.fore_colour = value[23:0];
                stored = 32'(value[23:0]);
            end
            mbce_pkg::REG_BACK_COLOUR:
            begin
                shadow_cfg.back_colour = value[23:0];
                stored = 32'(value[23:0]);
            end
            mbce_pkg::REG_ORIGIN_X:
            begin
                shadow_cfg.origin_x = value[11:0];
                stored = 32'(value[11:0]);
            end
            mbce_pkg::REG_ORIGIN_Y:
            begin
                shadow_cfg.origin_y = value[11:0];
                stored = 32'(value[11:0]);
            end
            mbce_pkg::REG_BYTES_PER_ROW:
            begin
                shadow_cfg.bytes_per_row = value[9:0];
                stored = 32'(value[9:0]);
            end
            mbce_pkg::REG_ROW_COUNT:
            begin
                shadow_cfg.row_count = value[11:0];
                stored = 32'(value[11:0]);
            end
            default: ;
        endcase
        return stored;
    endfunction

    // Expand one bitmap byte into its eight pixel writes and advance the position
    function automatic void expand_byte(logic [7:0] bits);
        logic [31:0]  rb;
        logic         row_end;
        logic         blit_end;
        logic [23:0]  colour;
        pixel_write_t w;
        int           i;
        rb = row_bytes_eff();
        row_end = (32'(byte_col) + 32'd1 >= rb);
        blit_end = row_end && (32'(blit_row) + 32'd1 >= rows_eff());
        // blit start picks up the current origin
        if (byte_col == '0 && blit_row == '0)
            next_offset = origin_offset();
        for (i = 0; i < mbce_pkg::PIX_PER_BYTE; i++)
        begin
            colour = bits[7 - i] ? shadow_cfg.fore_colour : shadow_cfg.back_colour;
            w.byte_offset  = next_offset;
            w.red          = colour[23:16];
            w.green        = colour[15:8];
            w.blue         = colour[7:0];
            w.last_of_byte = (i == mbce_pkg::PIX_PER_BYTE - 1);
            w.end_of_blit  = w.last_of_byte && blit_end;
            pending_pixels.push_back(w);
            next_offset += 32'(shadow_cfg.pixel_bytes);
        end
        if (blit_end)
        begin
            byte_col = '0;
            blit_row = '0;
            next_offset = origin_offset();
        end
        else if (row_end)
        begin
            next_offset += 32'(shadow_cfg.row_pitch)
                         - 32'(shadow_cfg.pixel_bytes) * 32'(mbce_pkg::PIX_PER_BYTE) * rb;
            byte_col = '0;
            blit_row = blit_row + 12'd1;
        end
        else
        begin
            byte_col = byte_col + 9'd1;
        end
    endfunction

    function automatic void check_field(string what, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h",
                         $realtime, what, expected, actual);
        end
    endfunction

    // Monitor: predict on accepted bytes, check accepted pixel writes
    logic byte_taken = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            byte_taken <= bitmap_ch.valid && bitmap_ch.ready;
            if (bitmap_ch.valid && bitmap_ch.ready)
                expand_byte(bitmap_ch.bitmap_byte);
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t unexpected pixel write at offset 0x%0h",
                                 $realtime, pixel_ch.byte_offset);
                end
                else
                begin
                    pixel_write_t w;
                    w = pending_pixels.pop_front();
                    check_field("byte_offset", w.byte_offset, pixel_ch.byte_offset);
                    check_field("red", 32'(w.red), 32'(pixel_ch.red));
                    check_field("green", 32'(w.green), 32'(pixel_ch.green));
                    check_field("blue", 32'(w.blue), 32'(pixel_ch.blue));
                    check_field("last_of_byte", 32'(w.last_of_byte), 32'(pixel_ch.last_of_byte));
                    check_field("end_of_blit", 32'(w.end_of_blit), 32'(pixel_ch.end_of_blit));
                end
            end
        end
    end

    // Byte driver: bursts of random length with random gaps
    int unsigned burst_left = 4;
    int unsigned gap_left = 0;

    always @(negedge clk)
    begin
        if (rst_n && (!bitmap_ch.valid || byte_taken))
        begin
            if (gap_left != 0)
            begin
                bitmap_ch.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (queued_bytes.size() != 0)
            begin
                bitmap_ch.valid <= 1'b1;
                bitmap_ch.bitmap_byte <= queued_bytes.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                bitmap_ch.valid <= 1'b0;
            end
        end
    end

    // Pixel sink: a 32-bit ready pattern rotated twice, then a fresh one
    logic [31:0] stall_bits = '1;
    logic [5:0]  stall_phase = '0;

    always @(negedge clk)
    begin
        if (stall_phase == '0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_bits <= '1;
                1:       stall_bits <= $urandom;
                default: stall_bits <= $urandom | $urandom;
            endcase
        end
        else
        begin
            stall_bits <= {stall_bits[0], stall_bits[31:1]};
        end
        stall_phase <= stall_phase + 6'd1;
        pixel_ch.ready <= stall_bits[0];
    end

    // APB write followed by a readback of the same register
    task automatic write_reg(input mbce_pkg::reg_idx_t idx, input logic [31:0] value);
        logic [31:0] stored;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        stored = apply_register(idx, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        psel <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        check_field("register readback", stored, prdata);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_geometry(input logic [31:0] pix_bytes, input logic [31:0] pitch,
                                input logic [31:0] fore, input logic [31:0] back,
                                input logic [31:0] ox, input logic [31:0] oy,
                                input logic [31:0] row_len, input logic [31:0] rows);
        write_reg(mbce_pkg::REG_PIXEL_BYTES, pix_bytes);
        write_reg(mbce_pkg::REG_ROW_PITCH, pitch);
        write_reg(mbce_pkg::REG_FORE_COLOUR, fore);
        write_reg(mbce_pkg::REG_BACK_COLOUR, back);
        write_reg(mbce_pkg::REG_ORIGIN_X, ox);
        write_reg(mbce_pkg::REG_ORIGIN_Y, oy);
        write_reg(mbce_pkg::REG_BYTES_PER_ROW, row_len);
        write_reg(mbce_pkg::REG_ROW_COUNT, rows);
    endtask

    // Hold off until every byte is sent and every pixel write has come back
    task automatic drain();
        while (queued_bytes.size() != 0 || pending_pixels.size() != 0 || bitmap_ch.valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        int unsigned random_sent;
        int unsigned n;
        int unsigned blit_len;
        logic [31:0] pb;
        logic [31:0] row_len;
        logic [31:0] rows;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        bitmap_ch.valid = 1'b0;
        bitmap_ch.bitmap_byte = '0;
        pixel_ch.ready = 1'b0;
        shadow_cfg.pixel_bytes = mbce_pkg::RST_PIXEL_BYTES;
        shadow_cfg.row_pitch = mbce_pkg::RST_ROW_PITCH;
        shadow_cfg.fore_colour = mbce_pkg::RST_FORE_COLOUR;
        shadow_cfg.back_colour = mbce_pkg::RST_BACK_COLOUR;
        shadow_cfg.origin_x = mbce_pkg::RST_ORIGIN_X;
        shadow_cfg.origin_y = mbce_pkg::RST_ORIGIN_Y;
        shadow_cfg.bytes_per_row = mbce_pkg::RST_BYTES_PER_ROW;
        shadow_cfg.row_count = mbce_pkg::RST_ROW_COUNT;
        next_offset = origin_offset();
        byte_col = '0;
        blit_row = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset geometry: one byte per row, row advance on every byte
        queued_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01};
        drain();

        // Four-byte pixels, far origin, zero row length and zero row count
        set_geometry(4, 65535, 24'h123456, 24'hFEDCBA, 4095, 4095, 0, 0);
        queued_bytes = '{8'hAA, 8'h55, 8'hFF};
        drain();

        // Zero pixel size, zero pitch, oversized row length
        set_geometry(0, 0, 24'h000000, 24'hFFFFFF, 17, 3, 700, 2);
        queued_bytes = '{8'h0F, 8'hF0, 8'h3C};
        drain();

        // Seven-byte pixels; origin and pixel size change mid-blit
        set_geometry(7, 100, 24'hFF0000, 24'h00FF00, 5, 1, 2, 3);
        queued_bytes = '{8'h81, 8'h7E, 8'hC3, 8'h24};
        drain();
        write_reg(mbce_pkg::REG_ORIGIN_X, 9);
        write_reg(mbce_pkg::REG_PIXEL_BYTES, 5);
        queued_bytes = '{8'h99, 8'h66, 8'h18, 8'hE7};
        drain();

        // One-byte pixels, longest row count, colors swapped
        set_geometry(1, 9, 24'h000000, 24'hFFFFFF, 0, 4095, 3, 4095);
        queued_bytes = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
        drain();

        // Random phases; geometry sometimes kept so a blit spans phases
        random_sent = 0;
        while (random_sent < 330)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                case ($urandom_range(0, 9))
                    0:       pb = 0;
                    1:       pb = $urandom_range(5, 7);
                    default: pb = $urandom_range(1, 4);
                endcase
                case ($urandom_range(0, 9))
                    0:       row_len = 0;
                    1:       row_len = $urandom_range(513, 1023);
                    default: row_len = $urandom_range(1, 6);
                endcase
                case ($urandom_range(0, 9))
                    0:       rows = 0;
                    1:       rows = $urandom_range(7, 4095);
                    default: rows = $urandom_range(1, 5);
                endcase
                set_geometry(pb, ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 65535),
                             $urandom, $urandom, $urandom_range(0, 4095),
                             $urandom_range(0, 4095), row_len, rows);
            end
            // Whole blits where they are short, otherwise a random stretch
            blit_len = row_bytes_eff() * rows_eff();
            if (blit_len <= 20)
                n = blit_len * $urandom_range(1, 2);
            else
                n = $urandom_range(4, 40);
            repeat (n) queued_bytes.push_back(8'($urandom));
            random_sent += n;
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mbce_pkg.sv
design/mbce_ifs.sv
design/mbce_cfg_regs.sv
design/mbce_lane.sv
design/mbce_serializer.sv
design/mono_bitmap_colour_expand_core.sv
tb/mono_bitmap_colour_expand_core_tb.sv
